FILE: design/icdf_pkg.sv
// Shared types and constants for the inverse-CDF quadratic sampler.
package icdf_pkg;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_NEG_DISC = 2'd1;
	localparam logic [1:0] ST_ZERO_DIV = 2'd2;

	localparam logic [8:0] BINS_RESET = 9'd100;

	typedef struct packed {
		logic               operation;
		logic [7:0]         bin_index;
		logic [24:0]        cdf_start;
		logic signed [31:0] bin_origin;
		logic signed [31:0] linear_coef;
		logic signed [31:0] quadratic_coef;
		logic [23:0]        uniform_sample;
	} item_t;

	typedef struct packed {
		logic signed [31:0] sample_value;
		logic [7:0]         bin_found;
		logic [1:0]         status;
	} result_t;

	// queue entry between front and back
	typedef struct packed {
		logic               is_load;
		logic [7:0]         bin;
		logic [24:0]        cdf;
		logic signed [31:0] origin;
		logic signed [31:0] lin;
		logic signed [31:0] quad;
		logic [23:0]        u;
	} job_t;

	typedef enum logic [3:0] {
		B_IDLE, B_SEARCH, B_RD, B_RDW, B_MUL1, B_MUL2, B_DISC, B_SQRT, B_DIVSET,
		B_DIV, B_FIN, B_OUT
	} bstate_t;

endpackage

FILE: design/icdf_front.sv
// Front end: accepts commands and queues them for the back end.
module icdf_front #(
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  icdf_pkg::item_t     item,
	output logic                busy,
	output logic                job_valid,
	output icdf_pkg::job_t      job,
	input  logic                job_take
);
	localparam int AW = $clog2(DEPTH);
	icdf_pkg::job_t q_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          push;

	assign busy      = (cnt_q == (AW+1)'(DEPTH));
	assign push      = start && !busy;
	assign job_valid = (cnt_q != '0);
	assign job       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q].is_load <= (item.operation == icdf_pkg::OP_LOAD);
			q_q[wp_q].bin     <= item.bin_index;
			q_q[wp_q].cdf     <= item.cdf_start;
			q_q[wp_q].origin  <= item.bin_origin;
			q_q[wp_q].lin     <= item.linear_coef;
			q_q[wp_q].quad    <= item.quadratic_coef;
			q_q[wp_q].u       <= item.uniform_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (job_take) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(job_take);
		end
	end
endmodule

FILE: design/icdf_back.sv
// Back end: bin table, binary search, square root and division.
module icdf_back #(
	parameter int MAX_BINS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [8:0]           bins_in_use,
	input  logic                 job_valid,
	input  icdf_pkg::job_t       job,
	output logic                 job_take,
	output logic                 res_strobe,
	output icdf_pkg::result_t    res
);
	localparam int IW = (MAX_BINS > 2) ? $clog2(MAX_BINS) : 1;
	localparam int NW = $clog2(MAX_BINS + 1) > 9 ? $clog2(MAX_BINS + 1) : 9;

	logic [24:0] cdf_mem [MAX_BINS];
	logic [95:0] coef_mem [MAX_BINS];

	icdf_pkg::bstate_t st_q, st_d;
	logic [NW-1:0] lo_q, hi_q, mid;
	logic [24:0]   srd_q;
	logic [95:0]   crd_q;
	logic [23:0]   u_q;
	logic signed [31:0] b_q, g_q, org_q;
	logic signed [25:0] rr_q;
	logic signed [63:0] bb_q, gr_q;
	logic [63:0]   rem_q, res_q, bit_q;
	logic [6:0]    cnt_q;
	logic          neg_q;
	logic [63:0]   num_q;
	logic [31:0]   den_q;
	logic [63:0]   quo_q;
	logic [1:0]    stat_q;
	icdf_pkg::result_t out_q;
	logic [NW-1:0] n_eff;
	logic          lin_q;

	always_comb begin
		n_eff = (NW)'(bins_in_use);
		if (bins_in_use == 9'd0) n_eff = (NW)'(1);
		if ((NW)'(bins_in_use) > (NW)'(MAX_BINS)) n_eff = (NW)'(MAX_BINS);
	end

	// one extra bit so the sum cannot wrap
	assign mid = NW'(({1'b0, lo_q} + {1'b0, hi_q}) >> 1);

	always_ff @(posedge clk) begin
		if (st_q == icdf_pkg::B_IDLE && job_valid && job.is_load
				&& NW'(job.bin) < NW'(MAX_BINS)) begin
			cdf_mem[IW'(job.bin)]  <= job.cdf;
			coef_mem[IW'(job.bin)] <= {job.origin, job.lin, job.quad};
		end
		srd_q <= cdf_mem[IW'(mid)];
		crd_q <= coef_mem[IW'(lo_q)];
	end

	always_comb begin
		st_d     = st_q;
		job_take = 1'b0;
		case (st_q)
			icdf_pkg::B_IDLE: if (job_valid) begin
				job_take = 1'b1;
				st_d = job.is_load ? icdf_pkg::B_IDLE : icdf_pkg::B_SEARCH;
			end
			icdf_pkg::B_SEARCH: st_d = (hi_q - lo_q > 1) ? icdf_pkg::B_RDW
				: icdf_pkg::B_RD;
			icdf_pkg::B_RDW:    st_d = icdf_pkg::B_SEARCH;
			icdf_pkg::B_RD:     st_d = icdf_pkg::B_MUL1;
			icdf_pkg::B_MUL1:   st_d = icdf_pkg::B_MUL2;
			icdf_pkg::B_MUL2:   st_d = icdf_pkg::B_DISC;
			icdf_pkg::B_DISC:   st_d = icdf_pkg::B_SQRT;
			icdf_pkg::B_SQRT:   st_d = (cnt_q == 0) ? icdf_pkg::B_DIVSET : icdf_pkg::B_SQRT;
			icdf_pkg::B_DIVSET: st_d = icdf_pkg::B_DIV;
			icdf_pkg::B_DIV:    st_d = (cnt_q == 0) ? icdf_pkg::B_FIN : icdf_pkg::B_DIV;
			icdf_pkg::B_FIN:    st_d = icdf_pkg::B_OUT;
			icdf_pkg::B_OUT:    st_d = icdf_pkg::B_IDLE;
			default:            st_d = icdf_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= icdf_pkg::B_IDLE;
		else st_q <= st_d;
	end

	assign res_strobe = (st_q == icdf_pkg::B_OUT);
	assign res = out_q;

	logic signed [64:0] dsum;
	logic signed [64:0] gr_t;
	logic [63:0] trial;
	logic [64:0] nrem;
	logic signed [33:0] smb;
	logic signed [65:0] x;
	logic signed [64:0] yq;

	always_comb begin
		// truncate toward zero on /256
		gr_t  = (gr_q < 0) ? -((-65'(gr_q)) >>> 8) : (65'(gr_q) >>> 8);
		dsum  = 65'(bb_q) + gr_t;
		trial = res_q + bit_q;
		nrem  = {rem_q, num_q[63]};
		smb   = 34'($signed({1'b0, res_q[32:0]})) - 34'(b_q);
		yq    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		x     = 66'(org_q) + 66'(yq);
	end

	always_ff @(posedge clk) begin
		case (st_q)
			icdf_pkg::B_IDLE: begin
				u_q  <= job.u;
				lo_q <= '0;
				hi_q <= n_eff;
			end
			icdf_pkg::B_RDW: begin
				if ({1'b0, u_q} >= srd_q) lo_q <= mid;
				else hi_q <= mid;
			end
			icdf_pkg::B_RD: ;
			icdf_pkg::B_MUL1: begin
				org_q <= crd_q[95:64];
				b_q   <= crd_q[63:32];
				g_q   <= crd_q[31:0];
				rr_q  <= 26'($signed({2'b0, u_q})) - 26'($signed({1'b0, srd_q}));
			end
			icdf_pkg::B_MUL2: begin
				bb_q <= b_q * b_q;
				gr_q <= 64'(g_q) * 64'(rr_q) * 64'sd2;
				lin_q <= (g_q == 0);
			end
			icdf_pkg::B_DISC: begin
				stat_q <= icdf_pkg::ST_OK;
				res_q  <= '0;
				bit_q  <= 64'h4000_0000_0000_0000;
				cnt_q  <= 7'd31;
				if (!lin_q) begin
					if (dsum < 0) stat_q <= icdf_pkg::ST_NEG_DISC;
					rem_q <= dsum[63:0];
				end else if (b_q == 0) begin
					stat_q <= icdf_pkg::ST_ZERO_DIV;
				end
			end
			icdf_pkg::B_SQRT: begin
				cnt_q <= cnt_q - 1'b1;
				if (!lin_q) begin
					if (rem_q >= trial) begin
						rem_q <= rem_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			icdf_pkg::B_DIVSET: begin
				rem_q <= '0;
				cnt_q <= 7'd63;
				if (lin_q) begin
					neg_q <= rr_q[25] ^ b_q[31];
					num_q <= 64'(rr_q[25] ? -34'(rr_q) <<< 8 : 34'(rr_q) <<< 8);
					den_q <= b_q[31] ? 32'(-33'(b_q)) : b_q;
				end else begin
					neg_q <= smb[33] ^ g_q[31];
					num_q <= 64'(smb[33] ? -50'(smb) <<< 16 : 50'(smb) <<< 16);
					den_q <= g_q[31] ? 32'(-33'(g_q)) : g_q;
				end
			end
			icdf_pkg::B_DIV: begin
				cnt_q <= cnt_q - 1'b1;
				if (nrem >= {33'b0, den_q}) begin
					rem_q <= 64'(nrem - {33'b0, den_q});
					quo_q <= {quo_q[62:0], 1'b1};
				end else begin
					rem_q <= nrem[63:0];
					quo_q <= {quo_q[62:0], 1'b0};
				end
				num_q <= num_q << 1;
			end
			icdf_pkg::B_FIN: begin
				out_q.bin_found <= lo_q[7:0];
				out_q.status    <= stat_q;
				if (stat_q != icdf_pkg::ST_OK) out_q.sample_value <= '0;
				else if (x > 66'sd2147483647) out_q.sample_value <= 32'h7FFF_FFFF;
				else if (x < -66'sd2147483648) out_q.sample_value <= 32'h8000_0000;
				else out_q.sample_value <= x[31:0];
			end
			default: ;
		endcase
	end
endmodule

FILE: design/inverse_cdf_quadratic_sampler.sv
// Top level of the piecewise-quadratic inverse-CDF sampler.
// A sample's time is set by the binary search over the table, the 32-step square root and
// the 64-step restoring divider in the back end; the last two produce one bit a cycle.
// Commands queue two deep ahead of the back end; the result strobe lasts one cycle and
// cannot be held off. Table entries read as undefined until loaded.
module inverse_cdf_quadratic_sampler #(
	parameter int MAX_BINS = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  icdf_pkg::item_t      item,
	output logic                 result_strobe,
	output icdf_pkg::result_t    result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [8:0]           cfg_data
);
	logic           job_valid, job_take;
	icdf_pkg::job_t job;
	logic [8:0]     bins_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bins_q <= icdf_pkg::BINS_RESET;
		else if (cfg_valid) bins_q <= cfg_data;
	end

	icdf_front u_front (
		.clk, .arst_n, .start, .item, .busy,
		.job_valid, .job, .job_take
	);

	icdf_back #(.MAX_BINS(MAX_BINS)) u_back (
		.clk, .arst_n, .bins_in_use(bins_q),
		.job_valid, .job, .job_take,
		.res_strobe(result_strobe), .res(result)
	);
endmodule
